// File: rtl/irt_pkg.sv
// shared constants and types for the interval reservation table
package irt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
  localparam int ROW_BITS      = 17;
  localparam int SEAT_BITS     = 16;
  localparam int OWNER_BITS    = 16;
  localparam int STATUS_BITS   = 3;

  localparam logic [STATUS_BITS-1:0] ST_RESERVED = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_OVERLAP  = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_OWNED    = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_FREE     = 3'd4;

  localparam logic MODE_RESERVE = 1'b0;
  localparam logic MODE_LOOKUP  = 1'b1;

  typedef struct packed {
    logic [ROW_BITS-1:0]   row;
    logic [SEAT_BITS-1:0]  first;
    logic [SEAT_BITS-1:0]  last;
    logic [OWNER_BITS-1:0] owner;
  } range_entry_t;

endpackage

// File: rtl/interval_reservation_table.sv
// interval reservation table: range store with serial overlap and owner search
//
//  channel | direction | beat fields                                           | handshake
//  --------+-----------+-------------------------------------------------------+---------------------
//  in      | input     | mode, row_number, first_seat, last_seat, owner_id,   | in_valid / in_stall
//          |           | query_seat                                            |
//  out     | output    | status, found_owner                                   | out_valid / out_stall
//
// a request sweeps the stored ranges through the single read port of the entry memory,
// one entry per cycle, so the time it takes grows with the number of stored ranges; a hit
// ends the sweep early
// rst is synchronous and clears the control state and the range count; the entry memory
// is not cleared, since only entries below the count are ever read, so no clearing pass
// in_stall is high while a request is at work; a finished result may wait in the output
// register while the next beat is taken, and the block holds in the finish state only
// when that register is still occupied by an earlier result under out_stall
module interval_reservation_table
  import irt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [ROW_BITS-1:0]    row_number,
  input  logic [SEAT_BITS-1:0]   first_seat,
  input  logic [SEAT_BITS-1:0]   last_seat,
  input  logic [OWNER_BITS-1:0]  owner_id,
  input  logic [SEAT_BITS-1:0]   query_seat,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_BITS-1:0] status,
  output logic [OWNER_BITS-1:0]  found_owner
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state;

  // latched request
  logic                  req_mode;
  logic [ROW_BITS-1:0]   req_row;
  logic [SEAT_BITS-1:0]  req_first;
  logic [SEAT_BITS-1:0]  req_last;
  logic [OWNER_BITS-1:0] req_owner;
  logic [SEAT_BITS-1:0]  req_seat;

  // sweep control
  logic [CNT_BITS-1:0]   range_count;
  logic [CNT_BITS-1:0]   issue_idx;
  logic                  rd_valid;
  logic                  rd_last;
  range_entry_t          rd_data;
  logic                  hit;
  logic [OWNER_BITS-1:0] hit_owner;

  // entry memory, one read and one write port
  range_entry_t mem [TABLE_ENTRIES];

  logic         in_accept;
  logic         issuing;
  logic         entry_match;
  logic         out_free;
  logic         table_full;
  logic         mem_we;
  range_entry_t wr_entry;

  assign in_stall   = (state != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign issuing    = (state == S_SCAN) && (issue_idx < range_count);
  assign out_free   = !out_valid || !out_stall;
  assign table_full = (range_count == CNT_BITS'(TABLE_ENTRIES));

  // reserve: closed ranges share a seat; lookup: seat lies inside the stored range
  always_comb begin
    if (req_mode == MODE_RESERVE) begin
      entry_match = (rd_data.row == req_row) &&
                    (req_last >= rd_data.first) && (req_first <= rd_data.last);
    end else begin
      entry_match = (rd_data.row == req_row) &&
                    (req_seat >= rd_data.first) && (req_seat <= rd_data.last);
    end
  end

  assign mem_we = (state == S_FINISH) && out_free && (req_mode == MODE_RESERVE) &&
                  !hit && !table_full;

  assign wr_entry = '{row: req_row, first: req_first, last: req_last, owner: req_owner};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[range_count[IDX_BITS-1:0]] <= wr_entry;
    end
    if (issuing) begin
      rd_data <= mem[issue_idx[IDX_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      range_count <= '0;
      issue_idx   <= '0;
      rd_valid    <= 1'b0;
      rd_last     <= 1'b0;
      hit         <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            req_mode  <= mode;
            req_row   <= row_number;
            req_first <= first_seat;
            req_last  <= last_seat;
            req_owner <= owner_id;
            req_seat  <= query_seat;
            issue_idx <= '0;
            rd_valid  <= 1'b0;
            rd_last   <= 1'b0;
            hit       <= 1'b0;
            // empty table: nothing to sweep
            state     <= (range_count == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_last <= (issue_idx == range_count - CNT_BITS'(1));
          if (issuing) begin
            issue_idx <= issue_idx + CNT_BITS'(1);
          end
          if (rd_valid && entry_match) begin
            // first hit in table order ends the sweep
            hit       <= 1'b1;
            hit_owner <= rd_data.owner;
            rd_valid  <= 1'b0;
            state     <= S_FINISH;
          end else if (rd_valid && rd_last) begin
            rd_valid <= 1'b0;
            state    <= S_FINISH;
          end else begin
            rd_valid <= issuing;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (req_mode == MODE_RESERVE) begin
              found_owner <= '0;
              if (hit) begin
                status <= ST_OVERLAP;
              end else if (table_full) begin
                status <= ST_FULL;
              end else begin
                status      <= ST_RESERVED;
                range_count <= range_count + CNT_BITS'(1);
              end
            end else begin
              if (hit) begin
                status      <= ST_OWNED;
                found_owner <= hit_owner;
              end else begin
                status      <= ST_FREE;
                found_owner <= '0;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // range count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    range_count <= CNT_BITS'(TABLE_ENTRIES))
    else $error("range count beyond table size");

  // every entry write grows the count by one
  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (range_count == $past(range_count) + CNT_BITS'(1)))
    else $error("entry write without count step");

  // owner is zero unless the seat was found owned
  a_owner_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OWNED)) |-> (found_owner == '0))
    else $error("owner set on a result that is not owned");

  // the sweep never issues a read at or past the table size
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    issuing |-> (issue_idx < CNT_BITS'(TABLE_ENTRIES)))
    else $error("read issued beyond table");

  // an accepted beat always blocks the input on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("input open while a request is at work");

endmodule

// File: tb/interval_reservation_table_tb.sv
// testbench for the interval reservation table: directed and random requests checked beat by beat
`timescale 1ns / 1ps

module interval_reservation_table_tb;
  import irt_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int PHASE_ITEMS  = RANDOM_ITEMS / 8;
  localparam int ROW_POOL     = 24;
  localparam logic [ROW_BITS-1:0]   ROW_MAX   = '1;
  localparam logic [SEAT_BITS-1:0]  SEAT_MAX  = '1;
  localparam logic [OWNER_BITS-1:0] OWNER_MAX = '1;

  // expected answer for one request, in the same order the block returns them
  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [OWNER_BITS-1:0]  owner;
  } seat_reply_t;

  // keeps its own copy of the range table and the replies still owed by the block
  class reservation_scoreboard;
    range_entry_t stored[$];
    seat_reply_t  pending[$];
    int errors;
    int n_reserve;
    int n_lookup;
    int outcome[8];

    function void note_request(logic md, logic [ROW_BITS-1:0] row,
                               logic [SEAT_BITS-1:0] first, logic [SEAT_BITS-1:0] last,
                               logic [OWNER_BITS-1:0] owner, logic [SEAT_BITS-1:0] seat);
      seat_reply_t  r;
      range_entry_t e;
      logic         hit;
      hit = 1'b0;
      r.owner = '0;
      if (md == MODE_RESERVE) begin
        n_reserve++;
        for (int i = 0; i < stored.size() && !hit; i++) begin
          if (stored[i].row == row && last >= stored[i].first && first <= stored[i].last)
            hit = 1'b1;
        end
        if (hit) begin
          r.status = ST_OVERLAP;
        end else if (stored.size() >= TABLE_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          e.row   = row;
          e.first = first;
          e.last  = last;
          e.owner = owner;
          stored.push_back(e);
          r.status = ST_RESERVED;
        end
      end else begin
        n_lookup++;
        r.status = ST_FREE;
        for (int i = 0; i < stored.size() && !hit; i++) begin
          if (stored[i].row == row && seat >= stored[i].first && seat <= stored[i].last) begin
            hit      = 1'b1;
            r.status = ST_OWNED;
            r.owner  = stored[i].owner;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [STATUS_BITS-1:0] st, logic [OWNER_BITS-1:0] own);
      seat_reply_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d owner %0h", $time, st, own);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (st !== exp.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $time, exp.status, st);
        errors++;
      end
      if (own !== exp.owner) begin
        $display("%0t: found_owner mismatch, expected %0h actual %0h", $time, exp.owner, own);
        errors++;
      end
      if (!$isunknown(st))
        outcome[st]++;
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   mode = MODE_RESERVE;
  logic [ROW_BITS-1:0]    row_number = '0;
  logic [SEAT_BITS-1:0]   first_seat = '0;
  logic [SEAT_BITS-1:0]   last_seat = '0;
  logic [OWNER_BITS-1:0]  owner_id = '0;
  logic [SEAT_BITS-1:0]   query_seat = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_BITS-1:0] status;
  logic [OWNER_BITS-1:0]  found_owner;

  reservation_scoreboard sb = new();

  // idle odds in percent per cycle, changed between phases
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // a handful of rows take most of the traffic so that ranges collide often
  logic [ROW_BITS-1:0] row_pool[ROW_POOL];

  interval_reservation_table u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .row_number  (row_number),
    .first_seat  (first_seat),
    .last_seat   (last_seat),
    .owner_id    (owner_id),
    .query_seat  (query_seat),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_owner (found_owner)
  );

  always #5 clk = ~clk;

  // receiver side: stall decided at the falling edge, so it is settled well before sampling
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // every result beat is compared with the oldest outstanding answer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, found_owner);
  end

  // one request beat: optional idle gap, then hold the payload until it is taken
  // the task is entered and left just after a falling edge
  task automatic send_request(input logic md, input logic [ROW_BITS-1:0] row,
                              input logic [SEAT_BITS-1:0] first,
                              input logic [SEAT_BITS-1:0] last,
                              input logic [OWNER_BITS-1:0] owner,
                              input logic [SEAT_BITS-1:0] seat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    mode       <= md;
    row_number <= row;
    first_seat <= first;
    last_seat  <= last;
    owner_id   <= owner;
    query_seat <= seat;
    in_valid   <= 1'b1;
    @(posedge clk);
    // stall is read before the edge's own updates land, i.e. as the block saw it
    while (in_stall)
      @(posedge clk);
    sb.note_request(md, row, first, last, owner, seat);
    @(negedge clk);
  endtask

  function automatic logic [ROW_BITS-1:0] pick_row();
    if ($urandom_range(99) < 85)
      return row_pool[$urandom_range(ROW_POOL - 1)];
    return ROW_BITS'($urandom_range(ROW_MAX));
  endfunction

  // random request: mostly short ranges in busy rows, lookups mostly aimed at stored ranges
  task automatic send_random();
    logic                  md;
    logic [ROW_BITS-1:0]   row;
    logic [SEAT_BITS-1:0]  first;
    logic [SEAT_BITS-1:0]  last;
    logic [SEAT_BITS-1:0]  seat;
    range_entry_t          e;
    int                    pick;
    md    = ($urandom_range(99) < 45) ? MODE_LOOKUP : MODE_RESERVE;
    row   = pick_row();
    // fields the mode does not use are left fully random
    first = SEAT_BITS'($urandom_range(SEAT_MAX));
    last  = SEAT_BITS'($urandom_range(SEAT_MAX));
    seat  = SEAT_BITS'($urandom_range(SEAT_MAX));
    if (md == MODE_RESERVE) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        first = SEAT_BITS'($urandom_range(511));
        last  = SEAT_BITS'(first + $urandom_range(15));
      end else if (pick < 85) begin
        // inverted range, first above last
        first = SEAT_BITS'($urandom_range(520, 1));
        last  = SEAT_BITS'($urandom_range(first - 1, 0));
      end
    end else if (sb.stored.size() != 0 && $urandom_range(99) < 70) begin
      e   = sb.stored[$urandom_range(sb.stored.size() - 1)];
      row = e.row;
      if (e.first <= e.last)
        seat = SEAT_BITS'($urandom_range(e.last, e.first));
      else
        seat = SEAT_BITS'($urandom_range(e.first, e.last));
    end else if ($urandom_range(99) < 60) begin
      seat = SEAT_BITS'($urandom_range(527));
    end
    send_request(md, row, first, last, OWNER_BITS'($urandom_range(OWNER_MAX)), seat);
  endtask

  // hard stop in case the block hangs
  initial begin
    #12_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int phase;
    row_pool[0] = '0;
    row_pool[1] = ROW_MAX;
    for (int i = 2; i < ROW_POOL; i++)
      row_pool[i] = ROW_BITS'($urandom_range(ROW_MAX));

    // synchronous reset, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part: empty table, extremes, touching and adjacent ranges
    send_request(MODE_LOOKUP, '0, '0, '0, '0, '0);
    send_request(MODE_RESERVE, '0, '0, '0, '0, SEAT_MAX);
    send_request(MODE_RESERVE, ROW_MAX, SEAT_MAX, SEAT_MAX, OWNER_MAX, '0);
    send_request(MODE_RESERVE, '0, '0, SEAT_MAX, 16'd1, '0);
    send_request(MODE_RESERVE, 17'd1, '0, SEAT_MAX, 16'haaaa, '0);
    send_request(MODE_RESERVE, 17'd1, 16'd5, 16'd5, 16'h1234, '0);
    send_request(MODE_RESERVE, 17'd2, 16'd100, 16'd200, 16'h5555, '0);
    // sharing only the end seat, then only the start seat
    send_request(MODE_RESERVE, 17'd2, 16'd200, 16'd300, 16'd6, '0);
    send_request(MODE_RESERVE, 17'd2, 16'd50, 16'd100, 16'd6, '0);
    // adjacent on both sides is allowed
    send_request(MODE_RESERVE, 17'd2, 16'd201, 16'd300, 16'd7, '0);
    send_request(MODE_RESERVE, 17'd2, 16'd99, 16'd99, 16'd8, '0);
    // inverted ranges go through the usual overlap test and may be stored
    send_request(MODE_RESERVE, 17'd3, 16'd500, 16'd400, 16'd9, '0);
    send_request(MODE_RESERVE, 17'd3, 16'd450, 16'd450, 16'd10, '0);
    send_request(MODE_RESERVE, 17'd3, 16'd600, 16'd300, 16'd11, '0);
    send_request(MODE_RESERVE, 17'd3, '0, SEAT_MAX, 16'd12, '0);
    send_request(MODE_LOOKUP, 17'd3, '0, '0, '0, 16'd450);
    // a seat inside an inverted range still reads as free
    send_request(MODE_LOOKUP, 17'd3, '0, '0, '0, 16'd420);
    send_request(MODE_LOOKUP, ROW_MAX, '0, '0, '0, SEAT_MAX);
    send_request(MODE_LOOKUP, ROW_MAX, '0, '0, '0, SEAT_MAX - 16'd1);
    // owned seat whose owner id is zero
    send_request(MODE_LOOKUP, '0, '0, '0, '0, '0);
    send_request(MODE_LOOKUP, 17'd1, '0, '0, '0, 16'h8000);
    send_request(MODE_LOOKUP, 17'd2, SEAT_MAX, SEAT_MAX, OWNER_MAX, 16'd150);
    // only the named row is searched
    send_request(MODE_LOOKUP, 17'd5, '0, '0, '0, 16'd150);
    send_request(MODE_RESERVE, 17'd4, 16'd10, 16'd20, 16'd13, SEAT_MAX);

    // random part: four idling patterns, each visited twice, the first once more for the items left over
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % PHASE_ITEMS == 0) begin
        phase = (k / PHASE_ITEMS) % 4;
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
          default: begin send_idle_pct = 30; recv_stall_pct = 30; end
        endcase
      end
      send_random();
    end
    in_valid <= 1'b0;

    // drain, then allow one full table sweep for any stray beat
    while (sb.pending.size() != 0)
      @(posedge clk);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    $display("ran %0d reserve and %0d lookup beats, %0d ranges stored",
             sb.n_reserve, sb.n_lookup, sb.stored.size());
    $display("outcomes: reserved %0d, overlap %0d, full %0d, owned %0d, free %0d",
             sb.outcome[ST_RESERVED], sb.outcome[ST_OVERLAP], sb.outcome[ST_FULL],
             sb.outcome[ST_OWNED], sb.outcome[ST_FREE]);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
